### src/tisp_pkg.sv
// Package for the lowercase-letter trie block: payload structs, operation codes,
// controller states and the command/status structs between controller and datapath.
// No dependencies; every other file in src imports it.
package tisp_pkg;

  localparam int DEF_NODE_COUNT = 1024;
  localparam int DEF_ALPHABET   = 26;
  localparam int LETTER_W       = 5;
  localparam int OP_W           = 2;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_SEARCH = 2'd1,
    OP_PREFIX = 2'd2
  } op_e;

  typedef struct packed {
    logic [OP_W-1:0]     op;
    logic [LETTER_W-1:0] letter;
    logic                last_letter;
    logic                no_letter;
  } in_t;

  typedef struct packed {
    logic found;
    logic pool_full;
  } out_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_MARK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic clear;
    logic accept;
    logic walk;
    logic mark;
    logic resp;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clear_done;
    logic ends;
    logic out_free;
  } ctrl_status_t;

endpackage

### src/trie_insert_search_prefix.sv
// A letter that does not end its word goes through a child read and a cursor update;
// the word's final letter or an empty word then also goes through the end-mark access
// and the result load into the output register, which waits until the output is free.
// One word is in flight at a time; the single-port child table and cursor chain set this.
// After reset a clearing pass zeroes the tables; in_ready_o stays low until it finishes.
module trie_insert_search_prefix #(
  parameter int NODE_COUNT = tisp_pkg::DEF_NODE_COUNT,
  parameter int ALPHABET   = tisp_pkg::DEF_ALPHABET
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  input  tisp_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output tisp_pkg::out_t out_data_o
);
  import tisp_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  tisp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  tisp_dp #(
    .NODE_COUNT (NODE_COUNT),
    .ALPHABET   (ALPHABET)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .status_o    (status),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

### src/tisp_ctrl.sv
// Controller state machine of the trie block: sequences the clearing pass,
// the per-letter child lookup, the end-mark access and the result load.
// Depends on tisp_pkg.
module tisp_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  tisp_pkg::ctrl_status_t status_i,
  output tisp_pkg::ctrl_cmd_t    cmd_o
);
  import tisp_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (status_i.clear_done) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_WALK;
      end
      ST_WALK: begin
        state_d = status_i.ends ? ST_MARK : ST_IDLE;
      end
      ST_MARK: begin
        state_d = ST_RESP;
      end
      ST_RESP: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_WALK: begin
        cmd_o.walk = 1'b1;
      end
      ST_MARK: begin
        cmd_o.mark = 1'b1;
      end
      ST_RESP: begin
        cmd_o.resp = status_i.out_free;
      end
      default: begin
      end
    endcase
  end

endmodule

### src/tisp_dp.sv
// Datapath of the trie block: child table and end-mark memories, cursor,
// free-node counter, word flags, clear counter and the result register.
// Depends on tisp_pkg; driven by tisp_ctrl commands.
module tisp_dp #(
  parameter int NODE_COUNT = tisp_pkg::DEF_NODE_COUNT,
  parameter int ALPHABET   = tisp_pkg::DEF_ALPHABET
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  tisp_pkg::ctrl_cmd_t    cmd_i,
  output tisp_pkg::ctrl_status_t status_o,
  input  tisp_pkg::in_t          in_data_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output tisp_pkg::out_t         out_data_o
);
  import tisp_pkg::*;

  localparam int NW    = $clog2(NODE_COUNT);
  localparam int FW    = $clog2(NODE_COUNT + 1);
  localparam int LW    = $clog2(ALPHABET);
  localparam int TOTAL = NODE_COUNT * ALPHABET;
  localparam int AW    = $clog2(TOTAL);
  localparam int LETTERS = 2 ** LETTER_W;

  logic [NW-1:0] child_mem [TOTAL];
  logic          end_mem   [NODE_COUNT];

  logic [AW-1:0] clr_cnt_q;
  logic [NW-1:0] cursor_q;
  logic [FW-1:0] next_free_q;
  op_e           word_op_q;
  logic          in_word_q;
  logic          path_missing_q;
  logic          overflowed_q;
  logic          out_valid_q;

  logic [AW-1:0] addr_q;
  logic [NW-1:0] child_q;
  logic          mark_q;
  logic          ends_q;
  logic          empty_q;
  out_t          out_data_q;

  // Letter values past the alphabet wrap around; this is a constant lookup.
  logic [LW-1:0] let_mod_tab [LETTERS];
  for (genvar g = 0; g < LETTERS; g++) begin : g_let_mod
    assign let_mod_tab[g] = LW'(g % ALPHABET);
  end

  logic [NW-1:0] cur_start;
  logic [AW-1:0] slot_d;
  op_e           op_map;
  logic          walk_go;
  logic          has_child;
  logic          room;
  logic          alloc;
  logic          child_we;
  logic [AW-1:0] child_waddr;
  logic [NW-1:0] child_wdata;
  logic          mark_we;
  logic [NW-1:0] mark_waddr;
  out_t          result;

  // A new word always starts from the root.
  assign cur_start = in_word_q ? cursor_q : '0;
  assign slot_d    = AW'(cur_start) * AW'(ALPHABET) + AW'(let_mod_tab[in_data_i.letter]);

  always_comb begin
    case (in_data_i.op)
      OP_INSERT: op_map = OP_INSERT;
      OP_SEARCH: op_map = OP_SEARCH;
      default:   op_map = OP_PREFIX;
    endcase
  end

  assign walk_go   = cmd_i.walk && !empty_q && !path_missing_q && !overflowed_q;
  assign has_child = (child_q != '0);
  assign room      = (next_free_q < FW'(NODE_COUNT));
  assign alloc     = walk_go && !has_child && (word_op_q == OP_INSERT) && room;

  assign child_we    = cmd_i.clear || alloc;
  assign child_waddr = cmd_i.clear ? clr_cnt_q : addr_q;
  assign child_wdata = cmd_i.clear ? '0 : next_free_q[NW-1:0];

  assign mark_we    = (cmd_i.clear && (clr_cnt_q < AW'(NODE_COUNT))) ||
                      (cmd_i.mark && (word_op_q == OP_INSERT) && !overflowed_q);
  assign mark_waddr = cmd_i.clear ? clr_cnt_q[NW-1:0] : cursor_q;

  always_comb begin
    result = '0;
    case (word_op_q)
      OP_INSERT: begin
        result.found     = !overflowed_q;
        result.pool_full = overflowed_q;
      end
      OP_SEARCH: begin
        result.found = !path_missing_q && mark_q;
      end
      default: begin
        result.found = !path_missing_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q      <= '0;
      cursor_q       <= '0;
      next_free_q    <= FW'(1);
      word_op_q      <= OP_INSERT;
      in_word_q      <= 1'b0;
      path_missing_q <= 1'b0;
      overflowed_q   <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cmd_i.clear) begin
        clr_cnt_q <= clr_cnt_q + AW'(1);
      end
      if (cmd_i.accept) begin
        in_word_q <= !(in_data_i.last_letter || in_data_i.no_letter);
        if (!in_word_q) begin
          word_op_q      <= op_map;
          cursor_q       <= '0;
          path_missing_q <= 1'b0;
          overflowed_q   <= 1'b0;
        end
      end
      if (walk_go) begin
        if (has_child) begin
          cursor_q <= child_q;
        end else if (word_op_q == OP_INSERT) begin
          if (room) begin
            cursor_q    <= next_free_q[NW-1:0];
            next_free_q <= next_free_q + FW'(1);
          end else begin
            overflowed_q <= 1'b1;
          end
        end else begin
          path_missing_q <= 1'b1;
        end
      end
      if (cmd_i.resp) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      addr_q  <= slot_d;
      ends_q  <= in_data_i.last_letter || in_data_i.no_letter;
      empty_q <= in_data_i.no_letter;
    end
    if (cmd_i.resp) begin
      out_data_q <= result;
    end
  end

  always_ff @(posedge clk_i) begin
    if (child_we) begin
      child_mem[child_waddr] <= child_wdata;
    end
    if (cmd_i.accept) begin
      child_q <= child_mem[slot_d];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mark_we) begin
      end_mem[mark_waddr] <= !cmd_i.clear;
    end
    if (cmd_i.mark) begin
      mark_q <= end_mem[cursor_q];
    end
  end

  assign status_o.clear_done = (clr_cnt_q == AW'(TOTAL - 1));
  assign status_o.ends       = ends_q;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  // The cursor only ever names a node that has been handed out.
  a_cursor_allocated: assert property (@(posedge clk_i) disable iff (!rst_ni)
    FW'(cursor_q) < next_free_q)
    else $error("cursor points past the allocated nodes");

  a_free_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_free_q <= FW'(NODE_COUNT))
    else $error("free counter ran past the pool");

  a_mark_after_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.mark |-> !in_word_q && ends_q)
    else $error("end mark accessed while a word is still open");

  a_alloc_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    alloc |=> next_free_q == $past(next_free_q) + FW'(1) && !overflowed_q)
    else $error("node allocation did not advance the free counter");

  a_result_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> !(out_data_q.found && out_data_q.pool_full))
    else $error("result reports success and pool exhaustion together");

endmodule
